[rtl/core/tcw_pkg.sv]
// text console writer: shared constants, mode and character codes,
// and the command/status structs between controller and datapath
// no dependencies
package tcw_pkg;

    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int CELL_W    = 16;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int CUR_W     = 11;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    // configuration register word indexes
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_BACK_COLOR = 1'b1;

    typedef struct packed {
        logic accept;      // latch the incoming transaction
        logic home;        // cursor to origin, hardware cursor to zero
        logic put;         // apply one put character
        logic read;        // issue the cell read
        logic sweep_run;   // walk the buffer one cell per cycle
        logic sweep_copy;  // sweep moves rows up, else it only blanks
        logic finish;      // load the result register
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              need_scroll;
        logic              sweep_last;
        logic              out_free;
    } t_status;

endpackage

[rtl/core/text_console_writer_top.sv]
// text console writer: top level with apb color registers
// depends on tcw_pkg, tcw_ctrl, tcw_datapath (tcw_ram below it)
//
//   channel   direction  handshake          payload
//   input     in         i_valid/o_stall    i_mode i_char_code i_move_cursor i_cell_index
//   result    out        o_valid/i_stall    o_cell_value o_column o_row o_hw_cursor
//   config    in         apb psel/penable   text_color @0x0, back_color @0x4
//
// a put or a read passes through dispatch, its own state and finish before the
// next accept, the unused mode 3 through dispatch and finish only; a put that
// scrolls adds a sweep over every cell through the single buffer ram port pair
// and a clear runs a blanking sweep; the result register is loaded in finish,
// holds while i_stall is high, and the next transaction is taken meanwhile
// synchronous active-low reset homes the cursor; buffer contents stay undefined
module text_console_writer_top #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tcw_pkg::MODE_W-1:0]    i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_move_cursor,
    input  logic [tcw_pkg::IDX_W-1:0]     i_cell_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_value,
    output logic [tcw_pkg::COL_OUT_W-1:0] o_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0] o_row,
    output logic [tcw_pkg::CUR_W-1:0]     o_hw_cursor,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [tcw_pkg::COLOR_W-1:0] r_text_color;
    logic [tcw_pkg::COLOR_W-1:0] r_back_color;
    logic                        cfg_wr;
    tcw_pkg::t_cmd               cmd;
    tcw_pkg::t_status            sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tcw_pkg::COLOR_W'(15);
            r_back_color <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                tcw_pkg::REG_TEXT_COLOR: r_text_color <= pwdata[tcw_pkg::COLOR_W-1:0];
                tcw_pkg::REG_BACK_COLOR: r_back_color <= pwdata[tcw_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tcw_pkg::REG_TEXT_COLOR: prdata = 32'(r_text_color);
            tcw_pkg::REG_BACK_COLOR: prdata = 32'(r_back_color);
            default:                 prdata = '0;
        endcase
    end

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcw_datapath #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_attr        ({r_back_color, r_text_color}),
        .i_mode        (i_mode),
        .i_char_code   (i_char_code),
        .i_move_cursor (i_move_cursor),
        .i_cell_index  (i_cell_index),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_cell_value  (o_cell_value),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_hw_cursor   (o_hw_cursor)
    );

endmodule

[rtl/core/tcw_ram.sv]
// text console writer: generic single-write, single-read ram
// registered read with read enable; no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/tcw_ctrl.sv]
// text console writer: controller state machine
// depends on tcw_pkg (t_cmd, t_status, mode codes)
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tcw_pkg::t_status i_sts,
    output tcw_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUT,
        S_READ,
        S_SWEEP,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_copy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_copy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (i_sts.mode)
                        tcw_pkg::MODE_PUT:  r_state <= S_PUT;
                        tcw_pkg::MODE_READ: r_state <= S_READ;
                        tcw_pkg::MODE_CLEAR: begin
                            r_state <= S_SWEEP;
                            r_copy  <= 1'b0;
                        end
                        default: r_state <= S_FINISH;
                    endcase
                end
                S_PUT: begin
                    if (i_sts.need_scroll) begin
                        r_state <= S_SWEEP;
                        r_copy  <= 1'b1;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_SWEEP: begin
                    if (i_sts.sweep_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == S_IDLE) && i_valid;
        o_cmd.home       = (r_state == S_DISPATCH) && (i_sts.mode == tcw_pkg::MODE_CLEAR);
        o_cmd.put        = (r_state == S_PUT);
        o_cmd.read       = (r_state == S_READ);
        o_cmd.sweep_run  = (r_state == S_SWEEP);
        o_cmd.sweep_copy = r_copy;
        o_cmd.finish     = (r_state == S_FINISH) && i_sts.out_free;
    end

    assign o_stall = (r_state != S_IDLE);

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted transaction did not reach dispatch");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && i_sts.sweep_last) |=> (r_state == S_FINISH))
        else $error("sweep did not end after its last cell");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_sts.out_free) |=> (r_state == S_FINISH))
        else $error("result dropped while output register was full");

endmodule

[rtl/core/tcw_datapath.sv]
// text console writer: cursor registers, put logic, buffer sweep and
// result register; depends on tcw_pkg and tcw_ram
module tcw_datapath #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcw_pkg::t_cmd                  i_cmd,
    output tcw_pkg::t_status               o_sts,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_attr,
    input  logic [tcw_pkg::MODE_W-1:0]     i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                           i_move_cursor,
    input  logic [tcw_pkg::IDX_W-1:0]      i_cell_index,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [tcw_pkg::CELL_W-1:0]     o_cell_value,
    output logic [tcw_pkg::COL_OUT_W-1:0]  o_column,
    output logic [tcw_pkg::ROW_OUT_W-1:0]  o_row,
    output logic [tcw_pkg::CUR_W-1:0]      o_hw_cursor
);

    localparam int NCELLS = COLS * ROWS;
    localparam int KEEP   = NCELLS - COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(COLS);
    localparam int RW     = $clog2(ROWS);
    localparam int TW     = $clog2(TAB_STOP);
    localparam int XW     = CW + 5;
    localparam int SW     = $clog2(NCELLS + 1);

    // latched transaction
    logic [tcw_pkg::MODE_W-1:0] r_mode;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic                       r_move;
    logic [tcw_pkg::IDX_W-1:0]  r_idx;

    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;
    logic [TW-1:0]              r_rem;   // column modulo tab stop
    logic [tcw_pkg::CUR_W-1:0]  r_shown;
    logic [SW-1:0]              r_sweep;

    logic                       r_out_valid;
    logic [tcw_pkg::CELL_W-1:0] r_res_cell;
    logic [CW-1:0]              r_res_col;
    logic [RW-1:0]              r_res_row;
    logic [tcw_pkg::CUR_W-1:0]  r_res_cur;

    logic [XW-1:0]              n_col_x;
    logic [TW-1:0]              n_rem;
    logic [RW:0]                n_row_x;
    logic                       put_wr;
    logic                       scroll;
    logic [AW-1:0]              cur_lin;
    logic [tcw_pkg::CUR_W-1:0]  n_shown;
    logic                       in_range;
    logic [SW-1:0]              sw_prev;

    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

    assign cur_lin  = AW'(r_row) * AW'(COLS) + AW'(r_col);
    assign in_range = 32'(r_idx) < NCELLS;
    assign sw_prev  = r_sweep - SW'(1);

    // one put character: position update, wrap and scroll detect
    always_comb begin
        n_col_x = XW'(r_col);
        n_rem   = r_rem;
        n_row_x = (RW+1)'(r_row);
        put_wr  = 1'b0;
        scroll  = 1'b0;
        case (r_char)
            tcw_pkg::CH_BS: begin
                if (r_col != '0) begin
                    n_col_x = XW'(r_col) - XW'(1);
                    n_rem   = (r_rem == '0) ? TW'(TAB_STOP - 1) : r_rem - TW'(1);
                end
            end
            tcw_pkg::CH_TAB: begin
                n_col_x = XW'(r_col) + XW'(TAB_STOP) - XW'(r_rem);
                n_rem   = '0;
            end
            tcw_pkg::CH_CR: begin
                n_col_x = '0;
                n_rem   = '0;
            end
            tcw_pkg::CH_LF: begin
                n_col_x = '0;
                n_rem   = '0;
                n_row_x = (RW+1)'(r_row) + (RW+1)'(1);
            end
            default: begin
                put_wr  = 1'b1;
                n_col_x = XW'(r_col) + XW'(1);
                n_rem   = (r_rem == TW'(TAB_STOP - 1)) ? '0 : r_rem + TW'(1);
            end
        endcase
        if (n_col_x >= XW'(COLS)) begin
            n_col_x = '0;
            n_rem   = '0;
            n_row_x = n_row_x + (RW+1)'(1);
        end
        if (n_row_x >= (RW+1)'(ROWS)) begin
            scroll  = 1'b1;
            n_row_x = (RW+1)'(ROWS - 1);
        end
    end

    // sweep step k writes cell k-1 from the read issued at step k-1, or a blank
    always_comb begin
        ram_rd_en   = (i_cmd.read && in_range) ||
                      (i_cmd.sweep_run && (r_sweep < SW'(KEEP)));
        ram_rd_addr = i_cmd.sweep_run ? AW'(r_sweep + SW'(COLS)) : AW'(r_idx);
        ram_wr_en   = (i_cmd.put && put_wr) || (i_cmd.sweep_run && (r_sweep != '0));
        ram_wr_addr = i_cmd.sweep_run ? AW'(sw_prev) : cur_lin;
        if (i_cmd.put) begin
            ram_wr_data = {i_attr, r_char};
        end else if (i_cmd.sweep_copy && (sw_prev < SW'(KEEP))) begin
            ram_wr_data = ram_rd_data;
        end else begin
            ram_wr_data = {i_attr, tcw_pkg::BLANK_CHAR};
        end
    end

    assign n_shown = ((r_mode == tcw_pkg::MODE_PUT) && r_move) ?
                     tcw_pkg::CUR_W'(cur_lin) : r_shown;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_move <= i_move_cursor;
            r_idx  <= i_cell_index;
        end
        if (i_cmd.finish) begin
            r_res_cell <= ((r_mode == tcw_pkg::MODE_READ) && in_range) ? ram_rd_data : '0;
            r_res_col  <= r_col;
            r_res_row  <= r_row;
            r_res_cur  <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_rem       <= '0;
            r_shown     <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.home) begin
                r_col   <= '0;
                r_row   <= '0;
                r_rem   <= '0;
                r_shown <= '0;
            end else if (i_cmd.put) begin
                r_col <= CW'(n_col_x);
                r_row <= RW'(n_row_x);
                r_rem <= n_rem;
            end else if (i_cmd.finish) begin
                r_shown <= n_shown;
            end
            r_sweep <= i_cmd.sweep_run ? r_sweep + SW'(1) : '0;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.mode        = r_mode;
        o_sts.need_scroll = scroll;
        o_sts.sweep_last  = (r_sweep == SW'(NCELLS));
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_cell_value = r_res_cell;
    assign o_column     = tcw_pkg::COL_OUT_W'(r_res_col);
    assign o_row        = tcw_pkg::ROW_OUT_W'(r_res_row);
    assign o_hw_cursor  = r_res_cur;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLS) && (32'(r_row) < ROWS))
        else $error("cursor position left the screen");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.accept, i_cmd.home, i_cmd.put, i_cmd.read,
                  i_cmd.sweep_run, i_cmd.finish}))
        else $error("controller issued overlapping commands");

    a_sweep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_run && !o_sts.sweep_last) |=> (r_sweep == $past(r_sweep) + SW'(1)))
        else $error("sweep counter skipped a cell");

endmodule
